// ===== design/stlb_pkg.sv =====
// shared constants, codes and item types of the scrolling text line buffer
`timescale 1ns / 1ps

package stlb_pkg;

  // storage geometry
  localparam int unsigned MaxColumns = 128;
  localparam int unsigned MaxRows    = 64;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned LenW       = ColW + 1;
  localparam int unsigned CountW     = RowW + 1;
  localparam int unsigned StoreAw    = RowW + ColW;
  localparam int unsigned StoreDepth = MaxRows * (2 ** ColW);

  // operation codes
  localparam logic OpPut  = 1'b0;
  localparam logic OpRead = 1'b1;

  // byte codes
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;

  // register indexes and reset values
  localparam logic [0:0] CfgColumns   = 1'b0;
  localparam logic [0:0] CfgRows      = 1'b1;
  localparam logic [7:0] ColumnsReset = 8'd80;
  localparam logic [6:0] RowsReset    = 7'd24;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_code;
    logic       accepted;
    logic [6:0] line_count;
    logic [5:0] bottom_row;
    logic [7:0] cursor_col;
  } out_item_t;

  typedef struct packed {
    logic [0:0] index;
    logic [7:0] value;
  } cfg_item_t;

endpackage

// ===== design/stlb_if.sv =====
// valid/ready channel interfaces for input, result and register write items
`timescale 1ns / 1ps

interface stlb_in_if;
  logic               valid;
  logic               ready;
  stlb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stlb_out_if;
  logic                valid;
  logic                ready;
  stlb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stlb_cfg_if;
  logic                valid;
  logic                ready;
  stlb_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/scrolling_text_line_buffer.sv =====
// Text screen store: one item per clock while the result path is not
// stalled, put and read. A printable put updates the cursor registers and
// writes the line length memory, and the character memory for a non-newline,
// at the edge that accepts it; a read addresses both memories at its accepting
// edge into registered read data, which is resolved into an output register
// when the stage moves on, and a new item can be taken while the last one is
// still in flight. The single port of the character memory, used by one item
// per cycle, sets that rate. Line lengths reset to zero through per-line
// valid bits, so the block is ready straight out of reset with no clearing
// pass; character cells are never cleared and are only read once written.
`timescale 1ns / 1ps

module scrolling_text_line_buffer (
  input logic       clk_i,
  input logic       rst_ni,
  stlb_cfg_if.sink  cfg_i,
  stlb_in_if.sink   in_i,
  stlb_out_if.source out_o
);

  typedef struct packed {
    logic                        is_read;
    logic                        row_ok;
    logic [6:0]                  read_col;
    logic                        accepted;
    logic [stlb_pkg::CountW-1:0] line_count;
    logic [stlb_pkg::RowW-1:0]   bottom_row;
    logic [stlb_pkg::LenW-1:0]   cursor_col;
  } meta_t;

  // slot arithmetic modulo MaxRows, input below twice MaxRows
  function automatic logic [stlb_pkg::RowW-1:0] wrap_slot(
    input logic [stlb_pkg::RowW:0] sum
  );
    logic [stlb_pkg::RowW:0] red;
    red = (sum >= (stlb_pkg::RowW+1)'(stlb_pkg::MaxRows)) ?
          sum - (stlb_pkg::RowW+1)'(stlb_pkg::MaxRows) : sum;
    return red[stlb_pkg::RowW-1:0];
  endfunction

  // memories
  logic [7:0]                char_mem [stlb_pkg::StoreDepth];
  logic [stlb_pkg::LenW-1:0] len_mem  [stlb_pkg::MaxRows];
  logic [stlb_pkg::MaxRows-1:0] len_vld_q;

  // configuration
  logic [7:0] columns_q;
  logic [6:0] rows_q;

  // screen state
  logic [stlb_pkg::RowW-1:0]   top_q, top_d;
  logic [stlb_pkg::CountW-1:0] held_q, held_d;
  logic [stlb_pkg::LenW-1:0]   cur_len_q, cur_len_d;

  // pipeline
  logic                      s1_v_q;
  meta_t                     s1_q, s1_d;
  logic [7:0]                char_rd_q;
  logic [stlb_pkg::LenW-1:0] len_rd_q;
  logic                      len_vld_rd_q;
  logic                      out_v_q;
  stlb_pkg::out_item_t       out_q, out_d;

  stlb_pkg::in_item_t          item;
  logic                        in_fire, s1_move;
  logic                        is_put, is_nl, printable, with_char, wrap;
  logic [stlb_pkg::LenW-1:0]   eff_cols, put_col, new_len, len_eff;
  logic [stlb_pkg::CountW-1:0] eff_rows, count;
  logic [stlb_pkg::RowW-1:0]   slot_last, slot_next, put_slot, rd_slot;
  logic                        char_we, len_we, hit;

  assign item    = in_i.data;
  assign s1_move = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s1_move;
  assign in_fire = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= stlb_pkg::ColumnsReset;
      rows_q    <= stlb_pkg::RowsReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        stlb_pkg::CfgColumns: columns_q <= cfg_i.data.value;
        stlb_pkg::CfgRows:    rows_q    <= cfg_i.data.value[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_cols = (stlb_pkg::LenW'(columns_q) > stlb_pkg::LenW'(stlb_pkg::MaxColumns)) ?
               stlb_pkg::LenW'(stlb_pkg::MaxColumns) : stlb_pkg::LenW'(columns_q);
    if (rows_q == 7'd0) begin
      eff_rows = stlb_pkg::CountW'(1);
    end else if (stlb_pkg::CountW'(rows_q) > stlb_pkg::CountW'(stlb_pkg::MaxRows)) begin
      eff_rows = stlb_pkg::CountW'(stlb_pkg::MaxRows);
    end else begin
      eff_rows = stlb_pkg::CountW'(rows_q);
    end
  end

  // put path: cursor update and memory write data
  always_comb begin
    is_put    = item.op == stlb_pkg::OpPut;
    is_nl     = item.char_code == stlb_pkg::CharNewline;
    with_char = item.char_code >= stlb_pkg::CharSpace;
    printable = !item.char_code[7] && (with_char || is_nl);
    slot_last = wrap_slot({1'b0, top_q} + (stlb_pkg::RowW+1)'(held_q - 1'b1));
    slot_next = wrap_slot({1'b0, top_q} + (stlb_pkg::RowW+1)'(held_q));
    wrap      = (cur_len_q >= eff_cols) || is_nl;
    put_slot  = wrap ? slot_next : slot_last;
    put_col   = wrap ? '0 : cur_len_q;
    count     = wrap ? held_q + 1'b1 : held_q;
    new_len   = with_char ? put_col + 1'b1 : '0;
    char_we   = in_fire && is_put && printable && with_char;
    len_we    = in_fire && is_put && printable;

    top_d     = top_q;
    held_d    = held_q;
    cur_len_d = cur_len_q;
    if (len_we) begin
      cur_len_d = new_len;
      held_d    = count;
      if (count > eff_rows) begin
        // surplus top lines scroll away
        top_d  = wrap_slot({1'b0, top_q} + (stlb_pkg::RowW+1)'(count - eff_rows));
        held_d = eff_rows;
      end
    end

    rd_slot = wrap_slot({1'b0, top_q} + (stlb_pkg::RowW+1)'(item.read_row));

    s1_d.is_read    = !is_put;
    s1_d.row_ok     = stlb_pkg::CountW'(item.read_row) < held_q;
    s1_d.read_col   = item.read_col;
    s1_d.accepted   = is_put && printable;
    s1_d.line_count = held_d;
    s1_d.bottom_row = stlb_pkg::RowW'(held_d - 1'b1);
    s1_d.cursor_col = cur_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= '0;
      held_q    <= stlb_pkg::CountW'(1);
      cur_len_q <= '0;
      len_vld_q <= '0;
    end else begin
      top_q     <= top_d;
      held_q    <= held_d;
      cur_len_q <= cur_len_d;
      if (len_we) begin
        len_vld_q[put_slot] <= 1'b1;
      end
    end
  end

  // character memory, one access per cycle
  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[{put_slot, put_col[stlb_pkg::ColW-1:0]}] <= item.char_code;
    end else if (in_fire && !is_put) begin
      char_rd_q <= char_mem[{rd_slot, item.read_col[stlb_pkg::ColW-1:0]}];
    end
  end

  // line length memory
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[put_slot] <= new_len;
    end else if (in_fire && !is_put) begin
      len_rd_q     <= len_mem[rd_slot];
      len_vld_rd_q <= len_vld_q[rd_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    len_eff = len_vld_rd_q ? len_rd_q : '0;
    hit     = s1_q.is_read && s1_q.row_ok && (stlb_pkg::LenW'(s1_q.read_col) < len_eff);
    out_d.cell_code  = hit ? char_rd_q : 8'd0;
    out_d.accepted   = s1_q.accepted;
    out_d.line_count = 7'(s1_q.line_count);
    out_d.bottom_row = 6'(s1_q.bottom_row);
    out_d.cursor_col = 8'(s1_q.cursor_col);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

// ===== design/stlb_checker.sv =====
// port checker for the scrolling text line buffer, bound to the top level
`timescale 1ns / 1ps

module stlb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input stlb_pkg::out_item_t out_data_i
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result item changed while stalled");

  a_row_follows_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.bottom_row == 6'(out_data_i.line_count - 7'd1))
    else $error("cursor row does not match line count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.line_count != 7'd0 &&
                    out_data_i.line_count <= 7'(stlb_pkg::MaxRows))
    else $error("line count out of range");

  // an accepted put never returns a character
  a_put_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.accepted |-> out_data_i.cell_code == 8'd0)
    else $error("put item returned a character");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.cursor_col <= 8'(stlb_pkg::MaxColumns))
    else $error("cursor column beyond line width");

endmodule

bind scrolling_text_line_buffer stlb_checker u_stlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
